// File: rtl/fpa_pkg.sv
`default_nettype none

package fpa_pkg;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_CREATE   = 2'd1,
    OP_FINALIZE = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOFIT    = 3'd1,
    ST_ZERO     = 3'd2,
    ST_BADMODE  = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FIT_FIRST   = 2'd0,
    FIT_BEST    = 2'd1,
    FIT_WORST   = 2'd2,
    FIT_INVALID = 2'd3
  } fit_mode_e;

  localparam int unsigned SizeW = 24;
  localparam int unsigned PidW  = 32;
  localparam int unsigned AddrW = 28;
  localparam int unsigned SlotW = 4;
  // Wide enough to compare a slot or an index against a partition count of up to 127.
  localparam int unsigned WideW = 7;

  typedef struct packed {
    logic [1:0]       operation;
    logic [PidW-1:0]  process_id;
    logic [SizeW-1:0] size_value;
    logic [SlotW-1:0] partition_slot;
  } alloc_req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [SlotW-1:0] chosen_partition;
    logic [AddrW-1:0] base_address;
    logic [AddrW-1:0] limit_address;
  } alloc_rsp_t;

  typedef struct packed {
    logic    capture;
    logic    rd_en;
    logic    emit;
    logic    emit_slot;
    status_e rsp_status;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic req_zero;
    logic mode_bad;
    logic found;
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/fpa_ctrl.sv
`default_nettype none

module fpa_ctrl #(
  parameter int unsigned NUM_PARTITIONS = 16,
  parameter int unsigned IdxW = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  output logic                    done_o,
  output fpa_pkg::dp_cmd_t        cmd_o,
  output logic [IdxW-1:0]         rd_addr_o,
  input  wire fpa_pkg::dp_status_t sts_i
);
  import fpa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_RESP
  } state_e;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_PARTITIONS - 1);

  state_e          state_q;
  logic [IdxW-1:0] cnt_q;
  status_e         st_q;
  logic            scan_q;
  logic            create_q;
  logic            done_q;
  logic            accept;
  status_e         resp_status;

  assign accept = start_i && (state_q == S_IDLE);

  always_comb begin
    resp_status = st_q;
    if (scan_q) begin
      if (sts_i.found) begin
        resp_status = ST_OK;
      end else if (create_q) begin
        resp_status = ST_NOFIT;
      end else begin
        resp_status = ST_NOTFOUND;
      end
    end
  end

  always_comb begin
    cmd_o.capture    = accept;
    cmd_o.rd_en      = (state_q == S_SCAN);
    cmd_o.emit       = (state_q == S_RESP);
    cmd_o.emit_slot  = (state_q == S_RESP) && scan_q && sts_i.found;
    cmd_o.rsp_status = resp_status;
  end

  assign rd_addr_o = cnt_q;
  assign busy_o    = (state_q != S_IDLE);
  assign done_o    = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      st_q     <= ST_OK;
      scan_q   <= 1'b0;
      create_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            cnt_q    <= '0;
            st_q     <= ST_OK;
            scan_q   <= 1'b0;
            create_q <= (sts_i.op == OP_CREATE);
            state_q  <= S_RESP;
            unique case (sts_i.op)
              OP_CREATE: begin
                if (sts_i.req_zero) begin
                  st_q <= ST_ZERO;
                end else if (sts_i.mode_bad) begin
                  st_q <= ST_BADMODE;
                end else begin
                  scan_q  <= 1'b1;
                  state_q <= S_SCAN;
                end
              end
              OP_FINALIZE: begin
                scan_q  <= 1'b1;
                state_q <= S_SCAN;
              end
              default: begin
                st_q <= ST_OK;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (cnt_q == LastIdx) begin
            state_q <= S_DRAIN;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_DRAIN: begin
          state_q <= S_RESP;
        end
        S_RESP: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/fpa_datapath.sv
`default_nettype none

module fpa_datapath #(
  parameter int unsigned NUM_PARTITIONS = 16,
  parameter int unsigned IdxW = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  input  wire logic [1:0]           cfg_wdata_i,
  input  wire fpa_pkg::alloc_req_t  req_i,
  input  wire fpa_pkg::dp_cmd_t     cmd_i,
  input  wire logic [IdxW-1:0]      rd_addr_i,
  output fpa_pkg::dp_status_t       sts_o,
  output fpa_pkg::alloc_rsp_t       rsp_o
);
  import fpa_pkg::*;

  fit_mode_e mode_q;

  // Captured item.
  op_e              op_q;
  logic [PidW-1:0]  pid_q;
  logic [SizeW-1:0] req_q;

  // Partition table. Sizes read as zero until their slot has been loaded.
  logic [SizeW-1:0]          size_mem  [NUM_PARTITIONS];
  logic [PidW-1:0]           owner_mem [NUM_PARTITIONS];
  logic [NUM_PARTITIONS-1:0] size_vld_q;
  logic [NUM_PARTITIONS-1:0] used_q;

  // Read stage.
  logic             rd_valid_q;
  logic [IdxW-1:0]  rd_idx_q;
  logic [SizeW-1:0] size_rd_q;
  logic [PidW-1:0]  owner_rd_q;
  logic             size_vld_rd_q;
  logic             used_rd_q;

  // Scan results.
  logic             found_q;
  logic [IdxW-1:0]  pick_idx_q;
  logic [AddrW-1:0] pick_base_q;
  logic [SizeW-1:0] pick_size_q;
  logic [AddrW-1:0] base_acc_q;

  alloc_rsp_t rsp_q;

  logic [WideW-1:0] slot_wide;
  logic             load_wr;
  logic [IdxW-1:0]  load_addr;
  logic [SizeW-1:0] size_eff;
  logic             take;
  logic [WideW-1:0] pick_wide;

  assign slot_wide = WideW'(req_i.partition_slot);
  assign load_wr   = cmd_i.capture && (op_e'(req_i.operation) == OP_LOAD) &&
                     (slot_wide < WideW'(NUM_PARTITIONS));
  assign load_addr = slot_wide[IdxW-1:0];
  assign size_eff  = size_vld_rd_q ? size_rd_q : '0;
  assign pick_wide = WideW'(pick_idx_q);

  always_comb begin
    take = 1'b0;
    if (rd_valid_q) begin
      if (op_q == OP_CREATE) begin
        if (!used_rd_q && (size_eff >= req_q)) begin
          if (!found_q) begin
            take = 1'b1;
          end else if (mode_q == FIT_BEST) begin
            take = (size_eff < pick_size_q);
          end else if (mode_q == FIT_WORST) begin
            take = (size_eff > pick_size_q);
          end
        end
      end else begin
        take = !found_q && used_rd_q && (owner_rd_q == pid_q);
      end
    end
  end

  always_comb begin
    sts_o.op       = op_e'(req_i.operation);
    sts_o.req_zero = (req_i.size_value == '0);
    sts_o.mode_bad = (mode_q == FIT_INVALID);
    sts_o.found    = found_q;
  end

  assign rsp_o = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= FIT_FIRST;
      size_vld_q <= '0;
      used_q     <= '0;
      rd_valid_q <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        mode_q <= fit_mode_e'(cfg_wdata_i);
      end
      if (load_wr) begin
        size_vld_q[load_addr] <= 1'b1;
      end
      rd_valid_q <= cmd_i.rd_en;
      if (cmd_i.capture) begin
        found_q <= 1'b0;
      end else if (take) begin
        found_q <= 1'b1;
      end
      if (cmd_i.emit_slot) begin
        used_q[pick_idx_q] <= (op_q == OP_CREATE);
      end
    end
  end

  // Payload registers and table memories.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q       <= op_e'(req_i.operation);
      pid_q      <= req_i.process_id;
      req_q      <= req_i.size_value;
      base_acc_q <= '0;
    end else if (rd_valid_q) begin
      base_acc_q <= base_acc_q + AddrW'(size_eff);
    end
    if (load_wr) begin
      size_mem[load_addr] <= req_i.size_value;
    end
    if (cmd_i.emit_slot && (op_q == OP_CREATE)) begin
      owner_mem[pick_idx_q] <= pid_q;
    end
    if (cmd_i.rd_en) begin
      rd_idx_q      <= rd_addr_i;
      size_rd_q     <= size_mem[rd_addr_i];
      owner_rd_q    <= owner_mem[rd_addr_i];
      size_vld_rd_q <= size_vld_q[rd_addr_i];
      used_rd_q     <= used_q[rd_addr_i];
    end
    if (take) begin
      pick_idx_q  <= rd_idx_q;
      pick_base_q <= base_acc_q;
      pick_size_q <= size_eff;
    end
    if (cmd_i.emit) begin
      if (cmd_i.emit_slot) begin
        rsp_q.status           <= ST_OK;
        rsp_q.chosen_partition <= pick_wide[SlotW-1:0];
        rsp_q.base_address     <= pick_base_q;
        rsp_q.limit_address    <= pick_base_q + AddrW'(pick_size_q);
      end else begin
        rsp_q.status           <= cmd_i.rsp_status;
        rsp_q.chosen_partition <= '0;
        rsp_q.base_address     <= '0;
        rsp_q.limit_address    <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/fixed_partition_allocator.sv
`default_nettype none

// Fixed-partition allocator with first, best and worst fit placement. A word is
// taken when start_i is high and busy_o is low. Each word gives exactly one
// result word on rsp_o, marked by done_o for a single cycle; the receiver cannot
// stall it, so it must take the word in that cycle. Loads, creates of size zero
// or under an invalid mode, and operation three go straight from acceptance to
// the response state. Other creates and finalizes walk the partition table one
// entry a cycle through its registered read port, then a drain state, before the
// response state. A new word may be offered in the cycle in which done_o is
// high. The fit mode register is written through cfg_valid_i, which is always
// ready; the user must write it only while idle, as the block does not check.
module fixed_partition_allocator #(
  parameter int unsigned NUM_PARTITIONS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [1:0]          cfg_wdata_i,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire fpa_pkg::alloc_req_t req_i,
  output logic                     done_o,
  output fpa_pkg::alloc_rsp_t      rsp_o
);
  import fpa_pkg::*;

  localparam int unsigned IdxW = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;

  dp_cmd_t         cmd;
  dp_status_t      sts;
  logic [IdxW-1:0] rd_addr;

  assign cfg_ready_o = 1'b1;

  fpa_ctrl #(
    .NUM_PARTITIONS(NUM_PARTITIONS),
    .IdxW          (IdxW)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .cmd_o    (cmd),
    .rd_addr_o(rd_addr),
    .sts_i    (sts)
  );

  fpa_datapath #(
    .NUM_PARTITIONS(NUM_PARTITIONS),
    .IdxW          (IdxW)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_i),
    .cmd_i      (cmd),
    .rd_addr_i  (rd_addr),
    .sts_o      (sts),
    .rsp_o      (rsp_o)
  );

endmodule

`default_nettype wire
